>>> rtl/avgdec_pkg.sv
`timescale 1ns / 1ps

package avgdec_pkg;

    localparam int MAX_OUTPUTS  = 65535;
    localparam int MAX_CHANNELS = 8;
    localparam int RATE_DIV     = 11025;
    localparam int RATE_BIAS    = 8812;
    localparam int SILENCE      = 128;
    localparam int MAX_RATIO    = (65535 + RATE_BIAS) / RATE_DIV;

    localparam int SUM_W  = 15;
    localparam int MAG_W  = 14;
    localparam int LEN_W  = 6;
    localparam int CNT_W  = 16;
    localparam int STEP_W = 4;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MAG_W - 1);

    localparam logic [1:0] REG_CHANNEL_COUNT   = 2'd0;
    localparam logic [1:0] REG_SAMPLE_RATE     = 2'd1;
    localparam logic [1:0] REG_BITS_PER_SAMPLE = 2'd2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_buffer;
    } in_item_t;

    typedef struct packed {
        logic [7:0]       pcm_out;
        logic [CNT_W-1:0] out_index;
    } out_item_t;

    typedef struct packed {
        logic accept;
        logic step;
        logic load;
    } dp_cmd_t;

    typedef struct packed {
        logic produce;
        logic out_busy;
    } dp_sts_t;

    function automatic logic [LEN_W-1:0] group_length(input logic [3:0]  channels,
                                                      input logic [15:0] rate);
        logic [3:0]       ch;
        logic [2:0]       ratio;
        logic [LEN_W-1:0] len;
        ch    = (channels > 4'(MAX_CHANNELS)) ? 4'(MAX_CHANNELS) : channels;
        ratio = '0;
        for (int k = 1; k <= MAX_RATIO; k++) begin
            if (rate >= 16'(k * RATE_DIV - RATE_BIAS)) begin
                ratio = ratio + 3'd1;
            end
        end
        len = LEN_W'(ch) * LEN_W'(ratio);
        return (len == '0) ? LEN_W'(1) : len;
    endfunction

endpackage

>>> rtl/averaging_decimator_to_u8_mono.sv
`timescale 1ns / 1ps
// Averaging decimator from raw PCM buffer bytes to mono unsigned 8-bit samples.
// The input channel carries one buffer byte per transfer, with end_of_buffer
// set on the final byte of the buffer. The result channel carries one
// averaged sample and its position within the current buffer per transfer.
// The configuration channel writes channel count, sample rate and bits per
// sample; it is always ready and a write restarts the current group.
// A byte that does not close a group is absorbed without a stall, so such bytes
// may be transferred back to back. A byte that closes a group starts a
// restoring divider that retires one quotient bit per cycle until the quotient
// is complete; the result is registered once the output register is free, and
// the input channel is ready again in the same cycle.
// A finished result waits in the output register while the next group's
// bytes are taken. If the receiver is still stalling when the following
// result is ready, the block holds off further input until the register
// is free.
// Reset restores one channel, 11025 Hz and 8 bits, empties the group and
// the output register, and restarts the sample position at zero.

module averaging_decimator_to_u8_mono
    import avgdec_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    assign cfg_ready = 1'b1;

    avgdec_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    avgdec_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .m_data    (m_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    a_divide_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && sts.produce) |=> !s_ready)
        else $error("input accepted while the divider was busy");

    a_load_shows_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> m_valid)
        else $error("loaded result not presented");

    a_reset_empties_output: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

>>> rtl/avgdec_ctrl.sv
`timescale 1ns / 1ps

module avgdec_ctrl
    import avgdec_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                cmd.accept = s_valid;
                if (s_valid && sts.produce) begin
                    state_next = ST_DIV;
                    step_next  = '0;
                end
            end
            ST_DIV: begin
                cmd.step  = 1'b1;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == LAST_STEP) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!sts.out_busy) begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule

>>> rtl/avgdec_dp.sv
`timescale 1ns / 1ps

module avgdec_dp
    import avgdec_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_data,
    input  in_item_t    s_data,
    output out_item_t   m_data,
    output logic        m_valid,
    input  logic        m_ready,
    input  dp_cmd_t     cmd,
    output dp_sts_t     sts
);

    logic [3:0]  channels_reg;
    logic [15:0] rate_reg;
    logic [5:0]  bps_reg;

    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [LEN_W-1:0]        fill_reg, fill_next;
    logic                    odd_reg, odd_next;
    logic [CNT_W-1:0]        count_reg, count_next;

    logic [MAG_W-1:0] quo_reg;
    logic [LEN_W-1:0] rem_reg;
    logic [LEN_W-1:0] dlen_reg;
    logic             neg_reg;
    logic             dwide_reg;
    logic [CNT_W-1:0] dindex_reg;

    logic      out_valid_reg;
    out_item_t out_reg;

    logic                    wide;
    logic                    contributes;
    logic [LEN_W-1:0]        len;
    logic [LEN_W:0]          fill_inc;
    logic                    group_done;
    logic signed [SUM_W-1:0] sum_add;
    logic signed [SUM_W-1:0] byte_ext;
    logic [SUM_W-1:0]        mag_full;
    logic                    start;
    logic                    cfg_hit;

    logic [LEN_W:0]   trial;
    logic             ge;
    logic [LEN_W:0]   diff;
    logic [7:0]       quo_low;
    logic [7:0]       pcm;

    assign wide        = (bps_reg > 6'd8);
    assign contributes = !wide || odd_reg;
    assign len         = group_length(channels_reg, rate_reg);
    assign fill_inc    = {1'b0, fill_reg} + (LEN_W + 1)'(1);
    assign group_done  = contributes && (fill_inc >= {1'b0, len});
    assign byte_ext    = wide ? SUM_W'(signed'(s_data.in_byte))
                              : SUM_W'(s_data.in_byte);
    assign sum_add     = sum_reg + byte_ext;
    assign mag_full    = sum_add[SUM_W-1] ? SUM_W'(-sum_add) : SUM_W'(sum_add);

    assign sts.produce  = group_done && (count_reg != CNT_W'(MAX_OUTPUTS));
    assign sts.out_busy = out_valid_reg && !m_ready;
    assign start        = cmd.accept && sts.produce;
    assign cfg_hit      = cfg_valid && (cfg_addr == REG_CHANNEL_COUNT
                                        || cfg_addr == REG_SAMPLE_RATE
                                        || cfg_addr == REG_BITS_PER_SAMPLE);

    always_comb begin
        sum_next   = sum_reg;
        fill_next  = fill_reg;
        odd_next   = odd_reg;
        count_next = count_reg;
        if (cmd.accept) begin
            if (wide) begin
                odd_next = !odd_reg;
            end
            if (contributes) begin
                if (group_done) begin
                    sum_next  = '0;
                    fill_next = '0;
                end else begin
                    sum_next  = sum_add;
                    fill_next = fill_inc[LEN_W-1:0];
                end
            end
            if (start) begin
                count_next = count_reg + CNT_W'(1);
            end
            if (s_data.end_of_buffer) begin
                sum_next   = '0;
                fill_next  = '0;
                odd_next   = 1'b0;
                count_next = '0;
            end
        end
        if (cfg_hit) begin
            sum_next  = '0;
            fill_next = '0;
            odd_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            channels_reg  <= 4'd1;
            rate_reg      <= 16'(RATE_DIV);
            bps_reg       <= 6'd8;
            sum_reg       <= '0;
            fill_reg      <= '0;
            odd_reg       <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_addr)
                    REG_CHANNEL_COUNT:   channels_reg <= cfg_data[3:0];
                    REG_SAMPLE_RATE:     rate_reg     <= cfg_data;
                    REG_BITS_PER_SAMPLE: bps_reg      <= cfg_data[5:0];
                    default: ;
                endcase
            end
            sum_reg   <= sum_next;
            fill_reg  <= fill_next;
            odd_reg   <= odd_next;
            count_reg <= count_next;
            if (cmd.load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign trial = {rem_reg, quo_reg[MAG_W-1]};
    assign ge    = (trial >= {1'b0, dlen_reg});
    assign diff  = trial - {1'b0, dlen_reg};

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg    <= mag_full[MAG_W-1:0];
            rem_reg    <= '0;
            dlen_reg   <= len;
            neg_reg    <= sum_add[SUM_W-1];
            dwide_reg  <= wide;
            dindex_reg <= count_reg;
        end else if (cmd.step) begin
            quo_reg <= {quo_reg[MAG_W-2:0], ge};
            rem_reg <= ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
        end
    end

    assign quo_low = quo_reg[7:0];
    assign pcm     = (neg_reg ? (~quo_low + 8'd1) : quo_low)
                   + (dwide_reg ? 8'(SILENCE) : 8'd0);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            out_reg.pcm_out   <= pcm;
            out_reg.out_index <= dindex_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule
